// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the priority queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("priority queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("priority queue check failed");

`endif

// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted array priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W   = 2;
	localparam int ST_W   = 2;

	// Operation codes carried on the input tuser.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	// Status codes carried on the output tuser.
	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [DATA_W-1:0] value;
	} res_t;

endpackage

// ===== rtl/sorted_array_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Bounded max-priority queue of signed 32-bit values with stream ports.
// ----------------------------------------------------------------------------
// The queue keeps up to DEPTH signed values in one RAM as a circular array in
// descending order. Each input beat carries an operation on s_tuser (insert,
// remove the highest, or clear) and a value on s_tdata, and yields exactly one
// output beat with a status, the removed value, and the occupancy after the
// operation. Equal values leave in the order they were inserted. The block
// works on one item at a time: s_tready is high only while it is idle. An
// insert walks the stored values from the tail toward the head, one RAM read
// and one RAM write per cycle, until it finds the slot for the new value. A
// remove reads the head entry from the RAM; a clear, an unused code, or a
// rejected insert or remove goes straight to the result state. The output
// register lets the next item start while the previous result beat still
// waits for m_tready.
// An insert into a full queue reports the full status, a remove from an empty
// queue reports the empty status with a zero value; neither changes the queue.
module sorted_array_priority_queue import spq_pkg::*; #(
	parameter int DEPTH = 32,
	localparam int IW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1),
	localparam int TDW = ((DATA_W + CW + 2 + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	// Input stream.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // value_in
	input  logic [OP_W-1:0]   s_tuser,  // op
	// Result stream.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [TDW-1:0]    m_tdata,  // value_out, entries, is_empty, is_full, zero pad
	output logic [ST_W-1:0]   m_tuser   // status
);

	logic              start;
	req_t              req;
	logic              core_idle;
	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic [CW-1:0]     count;

	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [IW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;

	logic              m_tvalid_q;
	logic [TDW-1:0]    m_tdata_q;
	logic [ST_W-1:0]   m_tuser_q;
	logic [TDW-1:0]    tdata_d;

	// The sequencer accepts a new beat only from its idle state.
	assign s_tready  = core_idle;
	assign start     = s_tvalid && s_tready;
	assign req.op    = s_tuser;
	assign req.value = s_tdata;

	// The output register frees when it is empty or its beat is being taken.
	assign res_ready = !m_tvalid_q || m_tready;

	spq_core #(
		.DEPTH(DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.idle     (core_idle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.count    (count),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	// The sorted values live here; nothing else holds a copy of them.
	spq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Pack the result fields from the lowest bit up; the pad stays zero.
	always_comb begin
		tdata_d                        = '0;
		tdata_d[DATA_W-1:0]            = res.value;
		tdata_d[DATA_W+CW-1:DATA_W]    = count;
		tdata_d[DATA_W+CW]             = (count == '0);
		tdata_d[DATA_W+CW+1]           = (count == CW'(DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= tdata_d;
			m_tuser_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== rtl/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/spq_core.sv =====
// ----------------------------------------------------------------------------
// spq_core
// Sequencer that keeps the queue sorted in the RAM by read-modify-write.
// ----------------------------------------------------------------------------
module spq_core import spq_pkg::*; #(
	parameter int DEPTH = 32,
	localparam int IW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  req_t              req,
	output logic              idle,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res,
	output logic [CW-1:0]     count,
	output logic              wr_en,
	output logic [IW-1:0]     wr_addr,
	output logic [DATA_W-1:0] wr_data,
	output logic [IW-1:0]     rd_addr,
	input  logic [DATA_W-1:0] rd_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_FETCH,
		S_FINISH
	} state_t;

	localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
	localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

	state_t            state_q;
	logic [IW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     k_q;
	logic [DATA_W-1:0] val_q;
	logic [ST_W-1:0]   status_q;
	logic [DATA_W-1:0] vout_q;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] k_m1;
	logic [CW-1:0] k_m2;
	logic          shift_go;

	// Physical slot for a logical offset from the head, wrapped once.
	function automatic logic [IW-1:0] slot(input logic [IW-1:0] head,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW + 1)'(head) + (CW + 1)'(off);
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[IW-1:0];
	endfunction

	assign cnt_m1   = (count_q != '0) ? count_q - CW'(1) : '0;
	assign k_m1     = (k_q != '0) ? k_q - CW'(1) : '0;
	assign k_m2     = (k_q > CW'(1)) ? k_q - CW'(2) : '0;
	// The entry below the gap moves down only when it is strictly smaller.
	assign shift_go = (k_q != '0) && ($signed(val_q) > $signed(rd_data));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot(head_q, k_q);
		wr_data = val_q;
		rd_addr = slot(head_q, cnt_m1);
		unique case (state_q)
			S_IDLE: begin
				if (start && req.op == OP_REMOVE) begin
					rd_addr = head_q;
				end
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				rd_addr = slot(head_q, k_m2);
				if (shift_go) begin
					wr_data = rd_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			k_q      <= '0;
			val_q    <= '0;
			status_q <= ST_DONE;
			vout_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						val_q    <= req.value;
						vout_q   <= '0;
						status_q <= ST_DONE;
						state_q  <= S_FINISH;
						case (req.op)
							OP_INSERT: begin
								if (count_q == FULL_C) begin
									status_q <= ST_FULL;
								end else begin
									k_q     <= count_q;
									state_q <= S_SHIFT;
								end
							end
							OP_REMOVE: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									state_q <= S_FETCH;
								end
							end
							OP_CLEAR: begin
								head_q  <= '0;
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					if (shift_go) begin
						k_q <= k_m1;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= S_FINISH;
					end
				end
				S_FETCH: begin
					vout_q  <= rd_data;
					count_q <= count_q - CW'(1);
					if (count_q == CW'(1)) begin
						head_q <= '0;
					end else begin
						head_q <= slot(head_q, CW'(1));
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle       = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_FINISH);
	assign res.status = status_q;
	assign res.value  = vout_q;
	assign count      = count_q;

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the priority queue, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker import spq_pkg::*; #(
	parameter int DEPTH = 32,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int TDW = ((DATA_W + CW + 2 + 7) / 8) * 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [TDW-1:0]    m_tdata,
	input logic [ST_W-1:0]   m_tuser
);

	logic [DATA_W-1:0] value_out;
	logic [CW-1:0]     entries;
	logic              is_empty;
	logic              is_full;

	assign value_out = m_tdata[DATA_W-1:0];
	assign entries   = m_tdata[DATA_W+CW-1:DATA_W];
	assign is_empty  = m_tdata[DATA_W+CW];
	assign is_full   = m_tdata[DATA_W+CW+1];

	// A waiting result beat keeps its contents.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// The queue works on one item at a time.
	`ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// The flags agree with the reported occupancy.
	`ASSERT_SAME(a_flags, clk, arst_n, m_tvalid, (is_empty == (entries == '0)) && (is_full == (entries == CW'(DEPTH))) && (entries <= CW'(DEPTH)))

	// A rejected insert is only ever seen against a full queue.
	`ASSERT_SAME(a_full_rej, clk, arst_n, m_tvalid && m_tuser == ST_FULL, is_full && value_out == '0)

	// A rejected remove is only ever seen against an empty queue.
	`ASSERT_SAME(a_empty_rej, clk, arst_n, m_tvalid && m_tuser == ST_EMPTY, is_empty && value_out == '0)

endmodule

bind sorted_array_priority_queue spq_checker #(
	.DEPTH(DEPTH)
) u_spq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// ===== tb/sv/tb_sorted_array_priority_queue.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_array_priority_queue
// Self-checking bench for the bounded max-priority queue with stream ports.
// ----------------------------------------------------------------------------
// Beats go in with random bursts and gaps while the result side stalls on its
// own pattern, with two long hold-offs to back the block up. A small scoreboard
// keeps its own sorted copy of the queue and checks every result beat field by
// field, in order. The stimulus opens with directed corner cases and then
// runs random mixes, fill runs that hit the full limit, and drain runs that
// hit the empty limit.
// ----------------------------------------------------------------------------
module tb_sorted_array_priority_queue;
	import spq_pkg::*;

	localparam int DEPTH       = 32;
	localparam int CW          = $clog2(DEPTH + 1);
	localparam int RES_W       = ((DATA_W + CW + 2 + 7) / 8) * 8;
	localparam int ITEMS       = 950;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT  = 3000;

	// The block ignores this op code; no package constant exists for it.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// One expected result beat.
	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [DATA_W-1:0] value;
		logic [CW-1:0]     entries;
		logic              is_empty;
		logic              is_full;
	} pq_result_t;

	// Scoreboard: a sorted copy of the queue plus the results still due.
	class pq_scoreboard;
		logic signed [DATA_W-1:0] held_values[$]; // largest first
		pq_result_t               due_results[$];
		int fail_count;
		int checked;
		int full_rejects;
		int empty_rejects;
		int peak_entries;

		function new();
			fail_count    = 0;
			checked       = 0;
			full_rejects  = 0;
			empty_rejects = 0;
			peak_entries  = 0;
		endfunction

		task report(string msg);
			fail_count++;
			if (fail_count <= 30) begin
				$display("%0t ns MISMATCH: %s", $time, msg);
			end
		endtask

		// Applies one accepted request to the copy and queues its result.
		function void apply_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] data);
			pq_result_t               res;
			logic signed [DATA_W-1:0] x;
			int                       pos;
			res = '0;
			res.status = ST_DONE;
			x = data;
			case (op)
				OP_INSERT: begin
					if (held_values.size() >= DEPTH) begin
						res.status = ST_FULL;
					end else begin
						// A new value goes behind every equal one, so ties stay in order.
						pos = 0;
						while (pos < held_values.size() && held_values[pos] >= x) pos++;
						held_values.insert(pos, x);
					end
				end
				OP_REMOVE: begin
					if (held_values.size() == 0) begin
						res.status = ST_EMPTY;
					end else begin
						res.value = held_values.pop_front();
					end
				end
				OP_CLEAR: begin
					held_values.delete();
				end
				default: begin
				end
			endcase
			res.entries  = CW'(held_values.size());
			res.is_empty = (held_values.size() == 0);
			res.is_full  = (held_values.size() == DEPTH);
			if (held_values.size() > peak_entries) peak_entries = held_values.size();
			due_results.push_back(res);
		endfunction

		// Compares one result beat with the oldest expectation.
		task check_result(logic [ST_W-1:0] status, logic [RES_W-1:0] data);
			pq_result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("result beat with nothing expected (status %0d)", status));
				return;
			end
			want = due_results.pop_front();
			checked++;
			if (want.status == ST_FULL) full_rejects++;
			if (want.status == ST_EMPTY) empty_rejects++;
			if (status !== want.status)
				report($sformatf("status got %0d want %0d", status, want.status));
			if (data[DATA_W-1:0] !== want.value)
				report($sformatf("value got %h want %h", data[DATA_W-1:0], want.value));
			if (data[DATA_W +: CW] !== want.entries)
				report($sformatf("entries got %0d want %0d", data[DATA_W +: CW], want.entries));
			if (data[DATA_W + CW] !== want.is_empty)
				report($sformatf("is_empty got %b want %b", data[DATA_W + CW], want.is_empty));
			if (data[DATA_W + CW + 1] !== want.is_full)
				report($sformatf("is_full got %b want %b", data[DATA_W + CW + 1], want.is_full));
			if (RES_W > DATA_W + CW + 2) begin
				if (data >> (DATA_W + CW + 2) !== '0)
					report("pad bits of the result are not zero");
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;  // value_in
	logic [OP_W-1:0]   s_tuser;  // op
	logic              m_tvalid;
	logic              m_tready;
	logic [RES_W-1:0]  m_tdata;  // value_out, entries, is_empty, is_full, zero pad
	logic [ST_W-1:0]   m_tuser;  // status

	pq_scoreboard sb;
	int           items_sent;
	int           burst_left;
	int           idle_cycles;
	bit           hold_request;

	sorted_array_priority_queue #(.DEPTH(DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Beats are taken at the rising edge. The request side is noted before the
	// result side; a result never leaves in the cycle its request enters, since
	// the block registers its output. The watchdog counts edges with no beat.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) sb.apply_request(s_tuser, s_tdata);
		if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Result side. It cycles through stretches of steady ready, coin flips,
	// mostly ready, and mostly stalled. When the stimulus asks for it, ready
	// stays low for a long count so the block fills and stops taking input.
	initial begin : result_sink
		int mode;
		int span;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(1, 32);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	// Offers one request beat and waits for the block to take it. Beats come
	// in bursts; at the start of each burst valid may drop for a random gap.
	// Within a burst valid stays high and only the payload changes.
	task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (op != OP_UNUSED) items_sent++;
	endtask

	// Value mix: mostly full-range random, with small values for ties and
	// the signed extremes.
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom;
			5, 6, 7: return DATA_W'($signed($urandom_range(0, 8)) - 4);
			8: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom)};
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return OP_INSERT;
		if (roll < 88) return OP_REMOVE;
		if (roll < 94) return OP_CLEAR;
		return OP_UNUSED;
	endfunction

	initial begin : stimulus
		int kind;
		int holds_done;
		sb           = new();
		items_sent   = 0;
		burst_left   = 0;
		idle_cycles  = 0;
		holds_done   = 0;
		hold_request = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = OP_INSERT;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: empty-queue rejects, clear and the ignored code on an
		// empty queue, signed extremes, ties at the top and the bottom, a clear
		// of a loaded queue, alternating bit patterns, and removing the last
		// value so the indices wrap back to the start.
		send_beat(OP_REMOVE, 32'hFFFF_FFFF);
		send_beat(OP_CLEAR,  32'hFFFF_FFFF);
		send_beat(OP_UNUSED, 32'h1234_5678);
		send_beat(OP_INSERT, 32'h0000_0000);
		send_beat(OP_INSERT, 32'h7FFF_FFFF);
		send_beat(OP_INSERT, 32'h8000_0000);
		send_beat(OP_INSERT, 32'hFFFF_FFFF);
		send_beat(OP_INSERT, 32'h0000_0001);
		send_beat(OP_INSERT, 32'h0000_0005);
		send_beat(OP_INSERT, 32'h0000_0005);
		send_beat(OP_INSERT, 32'h7FFF_FFFF);
		send_beat(OP_INSERT, 32'h8000_0000);
		send_beat(OP_UNUSED, 32'hFFFF_FFFF);
		repeat (4) send_beat(OP_REMOVE, $urandom);
		send_beat(OP_CLEAR,  32'h0000_0000);
		send_beat(OP_REMOVE, 32'h0000_0000);
		send_beat(OP_INSERT, 32'h5555_5555);
		send_beat(OP_INSERT, 32'hAAAA_AAAA);
		send_beat(OP_REMOVE, 32'h0000_0000);
		send_beat(OP_REMOVE, 32'h0000_0000);
		send_beat(OP_REMOVE, 32'h0000_0000);

		// Random part. Fill runs push past the full limit, drain runs past the
		// empty limit, and the rest are mixed requests. Twice along the way the
		// result side is told to hold off for a long stretch.
		while (items_sent < ITEMS) begin
			if ((holds_done == 0 && items_sent >= 60) || (holds_done == 1 && items_sent >= 600)) begin
				hold_request = 1'b1;
				holds_done++;
			end
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				repeat (DEPTH + $urandom_range(1, 4)) send_beat(OP_INSERT, pick_value());
			end else if (kind == 1) begin
				repeat (DEPTH + $urandom_range(1, 3)) send_beat(OP_REMOVE, $urandom);
			end else begin
				repeat ($urandom_range(4, 30)) send_beat(pick_op(), pick_value());
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;

		// Drain: wait for every due result, then give the block time to show
		// any stray beat.
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (sb.due_results.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.due_results.size()));

		$display("Checked %0d result beats over %0d requests; peak occupancy %0d of %0d.",
			sb.checked, items_sent, sb.peak_entries, DEPTH);
		$display("Rejected inserts on a full queue: %0d; rejected removes on an empty queue: %0d.",
			sb.full_rejects, sb.empty_rejects);
		if (sb.fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
